// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants and types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned POOL_WORDS = 1024;
  localparam int unsigned AW         = $clog2(POOL_WORDS);
  localparam int unsigned NW         = AW + 2;
  localparam int unsigned HW         = $clog2(POOL_WORDS * 8) + 1;

  localparam logic [HW-1:0] LIST_BYTES = HW'((POOL_WORDS - 1) * 8);
  localparam logic [HW-1:0] WORD_BYTES = HW'(8);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FREE_RD,
    ST_QRY_CHK,
    ST_M_START,
    ST_M_HDR,
    ST_M_NXT,
    ST_M_ZERO,
    ST_SCAN_START,
    ST_S_HDR,
    ST_A_WR,
    ST_A_REST,
    ST_Q_HDR,
    ST_RESP
  } state_t;

endpackage

// File: hw/rtl/first_fit_heap_allocator_core.sv
// Steps: a no-op, an oversize allocate or a free of an offset below 8 goes
//   straight to the response; a free or a query of a fully free pool reads one
//   header; other allocates and queries run a merge walk, then a search walk.
// Throughput: one request at a time; the next waits until the response is registered.
// Reset: synchronous; after reset the ST_INIT state writes header word 0 as a
//   single free chunk spanning the pool, during which no request is taken.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit free list held in a header RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command[1:0], request_bytes[17:2],
                                 // payload_offset_in[30:18], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // ok[0], payload_offset[13:1],
                                 // largest_bytes[26:14], zero pad
);

  localparam int unsigned AW = ffha_pkg::AW;
  localparam int unsigned NW = ffha_pkg::NW;
  localparam int unsigned HW = ffha_pkg::HW;

  // Header RAM: one write port, one registered read port.
  logic [HW-1:0] mem [ffha_pkg::POOL_WORDS];
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [HW-1:0] wr_data, rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  ffha_pkg::state_t state, state_next;
  ffha_pkg::cmd_t   cmd, cmd_next;
  logic [AW-1:0]    w, w_next;
  logic [HW-1:0]    h, h_next;
  logic [HW-1:0]    size, size_next;
  logic [12:0]      best, best_next;
  logic             res_ok, res_ok_next;
  logic [12:0]      res_pay, res_pay_next;
  logic [12:0]      res_big, res_big_next;
  logic             out_ok;
  logic [12:0]      out_pay, out_big;

  // Request fields.
  logic [1:0]  in_cmd;
  logic [15:0] in_req;
  logic [12:0] in_off;
  assign in_cmd = s_tdata[1:0];
  assign in_req = s_tdata[17:2];
  assign in_off = s_tdata[30:18];

  logic accept;
  assign s_tready = (state == ffha_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Round the request up to whole words.
  logic [16:0] req_sum, req_size;
  logic        too_big;
  assign req_sum  = {1'b0, in_req} + 17'd7;
  assign req_size = {req_sum[16:3], 3'b000};
  assign too_big  = req_size > 17'(ffha_pkg::LIST_BYTES);

  // Next header after the chunk at w, from fresh read data or held header.
  logic [NW-1:0] n_rd, n_h, n_nx;
  assign n_rd = NW'(w) + NW'(rdata[HW-1:3]) + NW'(1);
  assign n_h  = NW'(w) + NW'(h[HW-1:3]) + NW'(1);
  assign n_nx = n_h + NW'(rdata[HW-1:3]) + NW'(1);

  logic rd_free;
  assign rd_free = !rdata[0];

  // Split bookkeeping for allocate.
  logic [NW-1:0] rest;
  logic          do_split;
  assign rest     = NW'(w) + NW'(1) + NW'(size[HW-1:3]);
  assign do_split = ({1'b0, h} >= ({1'b0, size} + {1'b0, ffha_pkg::WORD_BYTES}));

  logic [AW-1:0] free_word;
  assign free_word = in_off[AW+2:3];

  logic out_load;
  assign out_load = (state == ffha_pkg::ST_RESP) && (!m_tvalid || m_tready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::ST_INIT: state_next = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (ffha_pkg::cmd_t'(in_cmd))
            ffha_pkg::CMD_ALLOC:
              state_next = too_big ? ffha_pkg::ST_RESP : ffha_pkg::ST_M_START;
            ffha_pkg::CMD_FREE:
              state_next = (free_word != '0) ? ffha_pkg::ST_FREE_RD : ffha_pkg::ST_RESP;
            ffha_pkg::CMD_QUERY: state_next = ffha_pkg::ST_QRY_CHK;
            ffha_pkg::CMD_NOP:   state_next = ffha_pkg::ST_RESP;
          endcase
        end
      end
      ffha_pkg::ST_FREE_RD: state_next = ffha_pkg::ST_RESP;
      ffha_pkg::ST_QRY_CHK:
        state_next = (rdata == ffha_pkg::LIST_BYTES) ? ffha_pkg::ST_RESP
                                                     : ffha_pkg::ST_M_START;
      ffha_pkg::ST_M_START: state_next = ffha_pkg::ST_M_HDR;
      ffha_pkg::ST_M_HDR: begin
        if (n_rd >= NW'(ffha_pkg::POOL_WORDS)) begin
          state_next = ffha_pkg::ST_SCAN_START;
        end else if (rd_free) begin
          state_next = ffha_pkg::ST_M_NXT;
        end
      end
      ffha_pkg::ST_M_NXT: begin
        if (rd_free) begin
          state_next = ffha_pkg::ST_M_ZERO;
        end else if (n_nx < NW'(ffha_pkg::POOL_WORDS)) begin
          state_next = ffha_pkg::ST_M_HDR;
        end else begin
          state_next = ffha_pkg::ST_SCAN_START;
        end
      end
      ffha_pkg::ST_M_ZERO:
        state_next = (n_h < NW'(ffha_pkg::POOL_WORDS)) ? ffha_pkg::ST_M_NXT
                                                       : ffha_pkg::ST_SCAN_START;
      ffha_pkg::ST_SCAN_START:
        state_next = (cmd == ffha_pkg::CMD_ALLOC) ? ffha_pkg::ST_S_HDR
                                                  : ffha_pkg::ST_Q_HDR;
      ffha_pkg::ST_S_HDR: begin
        if (rd_free && (rdata >= size)) begin
          state_next = ffha_pkg::ST_A_WR;
        end else if (n_rd >= NW'(ffha_pkg::POOL_WORDS)) begin
          state_next = ffha_pkg::ST_RESP;
        end
      end
      ffha_pkg::ST_A_WR:
        state_next = (do_split && (rest < NW'(ffha_pkg::POOL_WORDS)))
                     ? ffha_pkg::ST_A_REST : ffha_pkg::ST_RESP;
      ffha_pkg::ST_A_REST: state_next = ffha_pkg::ST_RESP;
      ffha_pkg::ST_Q_HDR:
        if (n_rd >= NW'(ffha_pkg::POOL_WORDS)) begin
          state_next = ffha_pkg::ST_RESP;
        end
      ffha_pkg::ST_RESP:
        if (out_load) begin
          state_next = ffha_pkg::ST_IDLE;
        end
      default: state_next = ffha_pkg::ST_IDLE;
    endcase
  end

  // Memory control and datapath updates.
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = w;
    wr_data      = h;
    rd_en        = 1'b0;
    rd_addr      = w;
    cmd_next     = cmd;
    w_next       = w;
    h_next       = h;
    size_next    = size;
    best_next    = best;
    res_ok_next  = res_ok;
    res_pay_next = res_pay;
    res_big_next = res_big;
    unique case (state)
      ffha_pkg::ST_INIT: begin
        // Seed one free chunk spanning the pool.
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = ffha_pkg::LIST_BYTES;
      end
      ffha_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_next     = ffha_pkg::cmd_t'(in_cmd);
          size_next    = HW'(req_size);
          res_ok_next  = !((in_cmd == ffha_pkg::CMD_ALLOC) && too_big);
          res_pay_next = '0;
          res_big_next = '0;
          if (in_cmd == ffha_pkg::CMD_FREE) begin
            w_next  = free_word - AW'(1);
            rd_en   = 1'b1;
            rd_addr = free_word - AW'(1);
          end else begin
            w_next  = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      ffha_pkg::ST_FREE_RD: begin
        // Clear the allocated mark, no checks.
        wr_en   = 1'b1;
        wr_data = {rdata[HW-1:1], 1'b0};
      end
      ffha_pkg::ST_QRY_CHK: begin
        if (rdata == ffha_pkg::LIST_BYTES) begin
          res_big_next = 13'(ffha_pkg::LIST_BYTES);
        end
      end
      ffha_pkg::ST_M_START: begin
        w_next  = '0;
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ffha_pkg::ST_M_HDR: begin
        if (n_rd < NW'(ffha_pkg::POOL_WORDS)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(n_rd);
          if (rd_free) begin
            h_next = rdata;
          end else begin
            w_next = AW'(n_rd);
          end
        end
      end
      ffha_pkg::ST_M_NXT: begin
        if (rd_free) begin
          // Absorb the neighbor: drop its header, grow ours.
          wr_en   = 1'b1;
          wr_addr = AW'(n_h);
          wr_data = '0;
          h_next  = h + rdata + ffha_pkg::WORD_BYTES;
        end else begin
          if (n_nx < NW'(ffha_pkg::POOL_WORDS)) begin
            w_next  = AW'(n_nx);
            rd_en   = 1'b1;
            rd_addr = AW'(n_nx);
          end
        end
      end
      ffha_pkg::ST_M_ZERO: begin
        wr_en   = 1'b1;
        wr_data = h;
        if (n_h < NW'(ffha_pkg::POOL_WORDS)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(n_h);
        end
      end
      ffha_pkg::ST_SCAN_START: begin
        w_next    = '0;
        best_next = '0;
        rd_en     = 1'b1;
        rd_addr   = '0;
      end
      ffha_pkg::ST_S_HDR: begin
        if (rd_free && (rdata >= size)) begin
          h_next = rdata;
        end else if (n_rd < NW'(ffha_pkg::POOL_WORDS)) begin
          w_next  = AW'(n_rd);
          rd_en   = 1'b1;
          rd_addr = AW'(n_rd);
        end else begin
          res_ok_next = 1'b0;
        end
      end
      ffha_pkg::ST_A_WR: begin
        wr_en        = 1'b1;
        wr_data      = {size[HW-1:1], 1'b1};
        res_pay_next = 13'({(AW + 1)'(w) + (AW + 1)'(1), 3'b000});
        if (do_split) begin
          w_next = AW'(rest);
          h_next = h - size - ffha_pkg::WORD_BYTES;
        end
      end
      ffha_pkg::ST_A_REST: begin
        wr_en = 1'b1;
      end
      ffha_pkg::ST_Q_HDR: begin
        if (rd_free && (13'(rdata) > best)) begin
          best_next = 13'(rdata);
        end
        if (n_rd < NW'(ffha_pkg::POOL_WORDS)) begin
          w_next  = AW'(n_rd);
          rd_en   = 1'b1;
          rd_addr = AW'(n_rd);
        end else begin
          res_big_next = (rd_free && (13'(rdata) > best)) ? 13'(rdata) : best;
        end
      end
      ffha_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffha_pkg::ST_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    w       <= w_next;
    h       <= h_next;
    size    <= size_next;
    best    <= best_next;
    res_ok  <= res_ok_next;
    res_pay <= res_pay_next;
    res_big <= res_big_next;
    if (out_load) begin
      out_ok  <= res_ok;
      out_pay <= res_pay;
      out_big <= res_big;
    end
  end

  assign m_tdata = {5'b0, out_big, out_pay, out_ok};

  `ASSERT_NEXT(a_one_in_flight, clk, rst, accept, !s_tready)
  `ASSERT_IMPL(a_rise_from_resp, clk, rst, $rose(m_tvalid),
               $past(state) == ffha_pkg::ST_RESP)
  `ASSERT_IMPL(a_merge_free, clk, rst, wr_en && (state == ffha_pkg::ST_M_ZERO),
               !wr_data[0])
  `ASSERT_IMPL(a_alloc_marked, clk, rst, wr_en && (state == ffha_pkg::ST_A_WR),
               wr_data[0])

endmodule

// File: verif/alloc_checker.sv
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request and response streams of the heap allocator, keeps its
// own copy of the header words, predicts each response and compares it.
// ----------------------------------------------------------------------------
module alloc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [31:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [31:0]                     m_tdata,
  input  logic                            end_of_test,
  output int                              fail_count,
  output int                              pending,
  output logic [ffha_pkg::POOL_WORDS-1:0] written_map,
  output logic [ffha_pkg::POOL_WORDS-1:0] busy_map
);

  typedef struct packed {
    logic        ok;
    logic [12:0] offset;
    logic [12:0] largest;
  } alloc_resp_t;

  logic [ffha_pkg::HW-1:0] hdr [ffha_pkg::POOL_WORDS];
  bit                      hdr_written [ffha_pkg::POOL_WORDS];
  alloc_resp_t             resp_q [$];
  bit                      drained;

  initial begin
    fail_count = 0;
    pending    = 0;
    drained    = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned next_hdr(input int unsigned w);
    return w + int'(hdr[w] >> 3) + 1;
  endfunction

  task automatic put_hdr(input int unsigned w, input logic [ffha_pkg::HW-1:0] v);
    hdr[w]         = v;
    hdr_written[w] = 1'b1;
  endtask

  // Fold every run of adjacent free chunks into its first chunk.
  task automatic coalesce();
    int unsigned w;
    int unsigned n;
    w = 0;
    while (w < ffha_pkg::POOL_WORDS) begin
      n = next_hdr(w);
      if (!hdr[w][0] && n < ffha_pkg::POOL_WORDS && !hdr[n][0]) begin
        put_hdr(w, hdr[w] + hdr[n] + ffha_pkg::WORD_BYTES);
        put_hdr(n, '0);
      end else begin
        w = n;
      end
    end
  endtask

  task automatic predict(input ffha_pkg::cmd_t cmd, input logic [15:0] req,
                         input logic [12:0] off, output alloc_resp_t r);
    int unsigned size;
    int unsigned w;
    int unsigned rest;
    int unsigned best;
    logic [ffha_pkg::HW-1:0] old;
    r = '{ok: 1'b1, offset: '0, largest: '0};
    case (cmd)
      ffha_pkg::CMD_ALLOC: begin
        size = (int'(req) + 7) & ~32'd7;
        if (size > int'(ffha_pkg::LIST_BYTES)) begin
          r.ok = 1'b0;
        end else begin
          coalesce();
          w = 0;
          while (w < ffha_pkg::POOL_WORDS && (hdr[w][0] || int'(hdr[w]) < size))
            w = next_hdr(w);
          if (w >= ffha_pkg::POOL_WORDS) begin
            r.ok = 1'b0;
          end else begin
            old = hdr[w];
            put_hdr(w, ffha_pkg::HW'(size) | ffha_pkg::HW'(1));
            // Split off the tail when a header still fits behind the chunk.
            if (int'(old) >= size + 8) begin
              rest = w + 1 + (size >> 3);
              if (rest < ffha_pkg::POOL_WORDS)
                put_hdr(rest, old - ffha_pkg::HW'(size) - ffha_pkg::WORD_BYTES);
            end
            r.offset = 13'((w + 1) * 8);
          end
        end
      end
      ffha_pkg::CMD_FREE: begin
        w = off >> 3;
        if (w >= 1) hdr[w-1][0] = 1'b0;
      end
      ffha_pkg::CMD_QUERY: begin
        if (hdr[0] == ffha_pkg::LIST_BYTES) begin
          r.largest = 13'(ffha_pkg::LIST_BYTES);
        end else begin
          coalesce();
          best = 0;
          w = 0;
          while (w < ffha_pkg::POOL_WORDS) begin
            if (!hdr[w][0] && int'(hdr[w]) > best) best = hdr[w];
            w = next_hdr(w);
          end
          r.largest = 13'(best);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    alloc_resp_t got;
    alloc_resp_t want;
    alloc_resp_t pred;
    logic [ffha_pkg::POOL_WORDS-1:0] wmap;
    logic [ffha_pkg::POOL_WORDS-1:0] bmap;
    if (rst) begin
      for (int i = 0; i < ffha_pkg::POOL_WORDS; i++) begin
        hdr[i]         = '0;
        hdr_written[i] = 1'b0;
      end
      put_hdr(0, ffha_pkg::LIST_BYTES);
      resp_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{ok: m_tdata[0], offset: m_tdata[13:1], largest: m_tdata[26:14]};
        if (resp_q.size() == 0) begin
          report("unexpected response, ok", got.ok, 0);
        end else begin
          want = resp_q.pop_front();
          if (got.ok !== want.ok) report("ok", got.ok, want.ok);
          if (got.offset !== want.offset) report("payload_offset", got.offset, want.offset);
          if (got.largest !== want.largest) report("largest_bytes", got.largest, want.largest);
        end
      end
      if (s_tvalid && s_tready) begin
        predict(ffha_pkg::cmd_t'(s_tdata[1:0]), s_tdata[17:2], s_tdata[30:18], pred);
        resp_q.push_back(pred);
      end
      if (end_of_test && !drained) begin
        drained = 1;
        foreach (resp_q[i]) report("missing response, offset", 0, resp_q[i].offset);
      end
    end
    for (int i = 0; i < ffha_pkg::POOL_WORDS; i++) begin
      wmap[i] = hdr_written[i];
      bmap[i] = hdr[i][0];
    end
    // Publish after the edge so the stimulus side reads a settled copy.
    written_map <= wmap;
    busy_map    <= bmap;
    pending     <= resp_q.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, query and no-op requests into the heap allocator with bursty
// input and a stalling output; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module testbench;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [31:0] m_tdata;
  logic end_of_test;
  int   fail_count;
  int   pending;
  logic [ffha_pkg::POOL_WORDS-1:0] written_map;
  logic [ffha_pkg::POOL_WORDS-1:0] busy_map;
  int   burst_left;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  alloc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .end_of_test(end_of_test), .fail_count(fail_count), .pending(pending),
    .written_map(written_map), .busy_map(busy_map)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: alternate stretches of always-ready with random stalling.
  initial m_tready = 1'b0;
  always @(posedge clk) begin
    int unsigned phase;
    phase = ($time / 12) % 600;
    if (phase < 200) m_tready <= 1'b1;
    else if (phase < 400) m_tready <= ($urandom_range(3) != 0);
    else m_tready <= ($urandom_range(3) == 0);
  end

  // Hold one request until it is taken; between bursts drop valid for a gap.
  task automatic send(input ffha_pkg::cmd_t cmd, input logic [15:0] req,
                      input logic [12:0] off);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, off, req, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(8);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6)) @(posedge clk);
    end
  endtask

  // Pick a free offset: mostly a live allocation, never an unwritten word.
  function automatic logic [12:0] pick_free_offset();
    int unsigned start;
    int unsigned w;
    bit want_busy;
    if ($urandom_range(19) == 0) return 13'($urandom_range(7));
    want_busy = ($urandom_range(99) < 80);
    start = $urandom_range(ffha_pkg::POOL_WORDS - 2);
    for (int i = 0; i < ffha_pkg::POOL_WORDS - 1; i++) begin
      w = (start + i) % (ffha_pkg::POOL_WORDS - 1);
      if (written_map[w] && (!want_busy || busy_map[w]))
        return 13'((w + 1) * 8 + $urandom_range(7));
    end
    return 13'(8 + $urandom_range(7));
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(256));
    if (r < 92) return 16'($urandom_range(2048));
    if (r < 97) return 16'($urandom_range(8184));
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned r;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    end_of_test <= 1'b0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: whole-pool query, zero-byte and tiny allocates, oversize,
    // no-fit, unaligned and out-of-range frees, free of a merged-away word.
    send(ffha_pkg::CMD_QUERY, 16'hFFFF, 13'h1FFF);
    send(ffha_pkg::CMD_ALLOC, 16'd0, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'd1, 13'h1FFF);
    send(ffha_pkg::CMD_ALLOC, 16'd8, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'hFFFF, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'd8184, 13'd0);
    send(ffha_pkg::CMD_FREE, 16'hFFFF, 13'd21);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd35);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd3);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd0);
    send(ffha_pkg::CMD_QUERY, 16'd0, 13'd0);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd32);
    send(ffha_pkg::CMD_NOP, 16'hFFFF, 13'h1FFF);
    send(ffha_pkg::CMD_ALLOC, 16'd8184, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'd8176, 13'd0);
    send(ffha_pkg::CMD_QUERY, 16'd0, 13'd0);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd8);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd16);
    send(ffha_pkg::CMD_QUERY, 16'd0, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'd8183, 13'd0);
    send(ffha_pkg::CMD_ALLOC, 16'd8185, 13'd0);
    send(ffha_pkg::CMD_FREE, 16'd0, 13'd15);
    send(ffha_pkg::CMD_QUERY, 16'd0, 13'd0);

    for (int n = 0; n < 290; n++) begin
      // Hold off once until the allocator has answered everything.
      if (n == 145) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 50) send(ffha_pkg::CMD_ALLOC, pick_size(), 13'($urandom));
      else if (r < 87) send(ffha_pkg::CMD_FREE, 16'($urandom), pick_free_offset());
      else if (r < 97) send(ffha_pkg::CMD_QUERY, 16'($urandom), 13'($urandom));
      else send(ffha_pkg::CMD_NOP, 16'($urandom), 13'($urandom));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3 * ffha_pkg::POOL_WORDS + 50) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ffha_pkg.sv
hw/rtl/first_fit_heap_allocator_core.sv
verif/alloc_checker.sv
verif/testbench.sv
